@@ hdl/rtc_counter_alarm_regs_core_macros.svh @@
// Assertion macros for the real-time clock core.
// Included by the top level; depends on nothing else.
`ifndef RTC_COUNTER_ALARM_REGS_CORE_MACROS_SVH
`define RTC_COUNTER_ALARM_REGS_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCAR_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rtc core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RCAR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rtc core: next-cycle check failed");

`endif

@@ hdl/rcar_pkg.sv @@
// Shared types and constants of the real-time clock core.
// Used by rcar_regs, rcar_outq and rtc_counter_alarm_regs_core; no dependencies.
`timescale 1ns / 1ps

package rcar_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    localparam logic [7:0] ADDR_CTRL    = 8'h08;
    localparam logic [7:0] ADDR_IRQ_EN  = 8'h10;
    localparam logic [7:0] ADDR_EVENTS  = 8'h14;
    localparam logic [7:0] ADDR_PAD     = 8'h24;
    localparam logic [7:0] ADDR_TIME_LO = 8'h40;
    localparam logic [7:0] ADDR_TIME_HI = 8'h44;
    localparam logic [7:0] ADDR_ALARM   = 8'h50;

    localparam logic [1:0] EN_RUN        = 2'h2;
    localparam int         ALARM_BIT     = 3;
    localparam int         SECS_SHIFT    = 15;
    localparam int         HIGH_BITS     = 15;
    localparam int         LOW_BITS      = 32;
    localparam int         DEADLINE_BITS = 47;

    typedef struct packed {
        op_t         op;
        logic [7:0]  addr;
        logic [31:0] data;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
    } result_t;

    typedef struct packed {
        logic head_valid;
        logic full;
    } q_status_t;

endpackage

@@ hdl/rcar_regs.sv @@
// Register file, time counter and alarm logic of the real-time clock core.
// Depends on rcar_pkg; produces the result of the item that it applies.
`timescale 1ns / 1ps

module rcar_regs #(
    parameter int COUNTER_BITS = 47
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_fire,
    input  rcar_pkg::item_t  item,
    output rcar_pkg::result_t result
);

    localparam int CMP_W = (COUNTER_BITS > rcar_pkg::DEADLINE_BITS) ?
                           COUNTER_BITS : rcar_pkg::DEADLINE_BITS;

    logic [COUNTER_BITS-1:0]        cnt_reg, cnt_next;
    logic [31:0]                    ctrl_reg, ctrl_next;
    logic [31:0]                    irqen_reg, irqen_next;
    logic [31:0]                    events_reg, events_next;
    logic [31:0]                    pad_reg, pad_next;
    logic [31:0]                    alarm_reg, alarm_next;
    logic [rcar_pkg::LOW_BITS-1:0]  staged_low_reg, staged_low_next;
    logic [rcar_pkg::HIGH_BITS-1:0] staged_high_reg, staged_high_next;
    logic                           pending_reg, pending_next;
    logic                           armed_reg, armed_next;

    logic [CMP_W-1:0]                   cnt_ext, cnt_new_ext, staged_ext, deadline_ext;
    logic [rcar_pkg::DEADLINE_BITS-1:0] staged_word, deadline;
    logic                               armed_pre, check_en, fire;
    logic [31:0]                        events_pre, rd;

    assign cnt_ext     = CMP_W'(cnt_reg);
    assign staged_word = {staged_high_reg, staged_low_reg};
    assign staged_ext  = CMP_W'(staged_word);

    always_comb begin
        cnt_next         = cnt_reg;
        ctrl_next        = ctrl_reg;
        irqen_next       = irqen_reg;
        events_pre       = events_reg;
        pad_next         = pad_reg;
        alarm_next       = alarm_reg;
        staged_low_next  = staged_low_reg;
        staged_high_next = staged_high_reg;
        pending_next     = pending_reg;
        armed_pre        = armed_reg;
        check_en         = 1'b0;
        rd               = '0;
        unique case (item.op)
            rcar_pkg::OP_TICK: begin
                cnt_next = cnt_reg + COUNTER_BITS'(1);
                check_en = 1'b1;
            end
            rcar_pkg::OP_READ: begin
                unique case (item.addr)
                    rcar_pkg::ADDR_CTRL:    rd = ctrl_reg;
                    rcar_pkg::ADDR_IRQ_EN:  rd = irqen_reg;
                    rcar_pkg::ADDR_EVENTS:  rd = events_reg;
                    rcar_pkg::ADDR_PAD:     rd = pad_reg;
                    rcar_pkg::ADDR_TIME_LO: rd = cnt_ext[31:0];
                    rcar_pkg::ADDR_TIME_HI: rd = 32'(cnt_ext[46:32]);
                    rcar_pkg::ADDR_ALARM:   rd = alarm_reg;
                    default:                rd = '0;
                endcase
            end
            rcar_pkg::OP_WRITE: begin
                unique case (item.addr)
                    rcar_pkg::ADDR_CTRL: begin
                        if (item.data[1:0] == rcar_pkg::EN_RUN &&
                            ctrl_reg[1:0] != rcar_pkg::EN_RUN && pending_reg) begin
                            cnt_next     = staged_ext[COUNTER_BITS-1:0];
                            pending_next = 1'b0;
                        end
                        ctrl_next = item.data;
                        armed_pre = item.data[rcar_pkg::ALARM_BIT];
                        check_en  = 1'b1;
                    end
                    rcar_pkg::ADDR_IRQ_EN: irqen_next = item.data;
                    rcar_pkg::ADDR_EVENTS: events_pre = events_reg & ~item.data;
                    rcar_pkg::ADDR_PAD:    pad_next   = item.data;
                    rcar_pkg::ADDR_TIME_LO: begin
                        staged_low_next = item.data;
                        pending_next    = 1'b1;
                    end
                    rcar_pkg::ADDR_TIME_HI: begin
                        staged_high_next = item.data[rcar_pkg::HIGH_BITS-1:0];
                        pending_next     = 1'b1;
                    end
                    rcar_pkg::ADDR_ALARM: begin
                        alarm_next = item.data;
                        armed_pre  = ctrl_reg[rcar_pkg::ALARM_BIT];
                        check_en   = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign cnt_new_ext  = CMP_W'(cnt_next);
    assign deadline     = {alarm_next, {rcar_pkg::SECS_SHIFT{1'b0}}};
    assign deadline_ext = CMP_W'(deadline);
    assign fire         = check_en && armed_pre && (cnt_new_ext >= deadline_ext);
    assign armed_next   = armed_pre && !fire;

    always_comb begin
        events_next = events_pre;
        if (fire) begin
            events_next[rcar_pkg::ALARM_BIT] = 1'b1;
        end
    end

    assign result.read_data = rd;
    assign result.irq = events_next[rcar_pkg::ALARM_BIT] & irqen_next[rcar_pkg::ALARM_BIT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg         <= '0;
            ctrl_reg        <= '0;
            irqen_reg       <= '0;
            events_reg      <= '0;
            pad_reg         <= '0;
            alarm_reg       <= '0;
            staged_low_reg  <= '0;
            staged_high_reg <= '0;
            pending_reg     <= 1'b0;
            armed_reg       <= 1'b0;
        end else if (item_fire) begin
            cnt_reg         <= cnt_next;
            ctrl_reg        <= ctrl_next;
            irqen_reg       <= irqen_next;
            events_reg      <= events_next;
            pad_reg         <= pad_next;
            alarm_reg       <= alarm_next;
            staged_low_reg  <= staged_low_next;
            staged_high_reg <= staged_high_next;
            pending_reg     <= pending_next;
            armed_reg       <= armed_next;
        end
    end

endmodule

@@ hdl/rcar_outq.sv @@
// Two-entry result queue that decouples the core from the result channel.
// Depends on rcar_pkg for the result and status types.
`timescale 1ns / 1ps

module rcar_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  rcar_pkg::result_t   push_data,
    input  logic                pop_ready,
    output rcar_pkg::result_t   head,
    output rcar_pkg::q_status_t status
);

    rcar_pkg::result_t head_reg, head_next;
    rcar_pkg::result_t tail_reg, tail_next;
    logic              v0_reg, v0_next;
    logic              v1_reg, v1_next;
    logic              pop;

    assign pop = v0_reg && pop_ready;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        v0_next   = v0_reg;
        v1_next   = v1_reg;
        if (pop) begin
            head_next = v1_reg ? tail_reg : push_data;
            v0_next   = v1_reg || push;
            v1_next   = v1_reg && push;
            if (v1_reg && push) begin
                tail_next = push_data;
            end
        end else if (push) begin
            if (!v0_reg) begin
                head_next = push_data;
                v0_next   = 1'b1;
            end else begin
                tail_next = push_data;
                v1_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign head              = head_reg;
    assign status.head_valid = v0_reg;
    assign status.full       = v1_reg;

endmodule

@@ hdl/rtc_counter_alarm_regs_core.sv @@
// Channel   | Direction | Ports
// ----------+-----------+-------------------------------------------------------
// s_        | in        | s_valid, s_ready, s_operation, s_address, s_write_data
// m_        | out       | m_valid, m_ready, m_read_data, m_interrupt_line
//
// One item is accepted per cycle while s_ready is high; its result passes through the input
// register into the head of the two-entry result queue, where m_valid offers it.
// The register file and counter update in the cycle that the item leaves the input register.
// aresetn clears the counter, every register of the register file and the valid flags of both handshake stages.
// s_ready falls only while the input register and both queue entries are occupied.
// Top level of the real-time clock core; depends on rcar_pkg, rcar_regs and rcar_outq.
`timescale 1ns / 1ps
`include "rtc_counter_alarm_regs_core_macros.svh"

module rtc_counter_alarm_regs_core #(
    parameter int COUNTER_BITS = 47
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [7:0]  s_address,
    input  logic [31:0] s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_interrupt_line
);

    rcar_pkg::item_t     in_item_reg, in_item_next;
    logic                in_valid_reg, in_valid_next;
    logic                s_accept, in_fire;
    rcar_pkg::result_t   result, head;
    rcar_pkg::q_status_t q_status;

    assign in_fire  = in_valid_reg && !q_status.full;
    assign s_ready  = !in_valid_reg || !q_status.full;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_accept) begin
            in_valid_next     = 1'b1;
            in_item_next.op   = rcar_pkg::op_t'(s_operation);
            in_item_next.addr = s_address;
            in_item_next.data = s_write_data;
        end else if (in_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
    end

    rcar_regs #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (in_fire),
        .item      (in_item_reg),
        .result    (result)
    );

    rcar_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .push_data (result),
        .pop_ready (m_ready),
        .head      (head),
        .status    (q_status)
    );

    assign m_valid          = q_status.head_valid;
    assign m_read_data      = head.read_data;
    assign m_interrupt_line = head.irq;

    `RCAR_ASSERT_SAME(a_stall_cause, aclk, aresetn, !s_ready, in_valid_reg && q_status.full)
    `RCAR_ASSERT_NEXT(a_fire_gives_result, aclk, aresetn, in_fire, q_status.head_valid)
    `RCAR_ASSERT_SAME(a_full_has_head, aclk, aresetn, q_status.full, q_status.head_valid)

endmodule
